// File: hdl/ipsl_pkg.sv
// shared types and constants of the incremental pid step limiter
// no dependencies
`default_nettype none

package ipsl_pkg;

	localparam int VALUE_WIDTH = 16;
	localparam int GAIN_W      = 16;
	localparam int CFG_W       = (VALUE_WIDTH > GAIN_W) ? VALUE_WIDTH : GAIN_W;
	localparam int IDX_W       = 3;
	localparam int MODE_W      = 3;
	localparam int ERR_W       = VALUE_WIDTH + 1;
	localparam int D1_W        = VALUE_WIDTH + 2;
	localparam int D2_W        = VALUE_WIDTH + 3;
	localparam int PROD_W      = GAIN_W + D2_W;
	localparam int DELTA_W     = PROD_W + 2;
	localparam int TOT_W       = DELTA_W + 1;
	localparam int RES_W       = TOT_W - 8;
	localparam int QUOT_W      = VALUE_WIDTH - 6;

	localparam logic [MODE_W-1:0] MODE_NORMAL = 3'd0;
	localparam logic [MODE_W-1:0] MODE_STABLE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FAST   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SLOW   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_PI     = 3'd4;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd5;

	localparam logic [IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
	localparam logic [IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
	localparam logic [IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
	localparam logic [IDX_W-1:0] REG_DRIVE_MAX  = 3'd3;
	localparam logic [IDX_W-1:0] REG_DRIVE_MIN  = 3'd4;

	typedef struct packed {
		logic [MODE_W-1:0]      mode;
		logic [VALUE_WIDTH-1:0] setpoint;
		logic [VALUE_WIDTH-1:0] measured;
		logic [VALUE_WIDTH-1:0] present_drive;
	} in_item_t;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] drive;
		logic                   near_target;
	} out_item_t;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] coarse_fast;
		logic [VALUE_WIDTH-1:0] coarse_slow;
		logic [VALUE_WIDTH-1:0] band_normal;
		logic [VALUE_WIDTH-1:0] band_stable;
		logic [VALUE_WIDTH-1:0] band_tight;
	} caps_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] prop_gain;
		logic signed [GAIN_W-1:0] integ_gain;
		logic signed [GAIN_W-1:0] deriv_gain;
		logic [VALUE_WIDTH-1:0]   drive_max;
		logic [VALUE_WIDTH-1:0]   drive_min;
		caps_t                    caps;
	} cfg_t;

	typedef struct packed {
		logic [MODE_W-1:0]      mode;
		logic [VALUE_WIDTH-1:0] setpoint;
		logic [VALUE_WIDTH-1:0] measured;
		logic [VALUE_WIDTH-1:0] present_drive;
		logic signed [ERR_W-1:0] err;
		logic signed [D1_W-1:0]  d1;
		logic signed [D2_W-1:0]  d2;
	} err_stage_t;

	typedef struct packed {
		logic [MODE_W-1:0]        mode;
		logic [VALUE_WIDTH-1:0]   present_drive;
		logic                     near;
		logic signed [PROD_W-1:0] p_prop;
		logic signed [PROD_W-1:0] p_integ;
		logic signed [PROD_W-1:0] p_deriv;
	} gain_stage_t;

endpackage

`default_nettype wire

// File: hdl/ipsl_cfg_regs.sv
// configuration registers and precomputed delta caps
// depends on ipsl_pkg
`default_nettype none

module ipsl_cfg_regs
	import ipsl_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	localparam int W = VALUE_WIDTH;
	localparam logic [W:0] RECIP_100 =
		(W+1)'(((64'd1 << (W + 7)) + 64'd99) / 64'd100);
	localparam logic [QUOT_W-1:0] DMAX_QUOT = QUOT_W'(((64'd1 << W) - 64'd1) / 64'd100);
	localparam logic [6:0]        DMAX_REM  = 7'(((64'd1 << W) - 64'd1) % 64'd100);

	logic signed [GAIN_W-1:0] prop_gain_q;
	logic signed [GAIN_W-1:0] integ_gain_q;
	logic signed [GAIN_W-1:0] deriv_gain_q;
	logic [W-1:0]             drive_max_q;
	logic [W-1:0]             drive_min_q;
	logic [QUOT_W-1:0]        dmax_quot_q;
	logic [6:0]               dmax_rem_q;
	caps_t                    caps_q;

	logic [W-1:0]      wr_value;
	logic [2*W:0]      recip_prod;
	logic [QUOT_W-1:0] wr_quot;
	logic [W-1:0]      wr_rem_full;

	// floor((q*100 + r) * n / 100) = q*n + floor(r*n / 100)
	function automatic logic [W-1:0] cap_of(input logic [QUOT_W-1:0] q,
			input logic [6:0] r, input logic [5:0] n);
		logic [12:0] rn;
		logic [25:0] scaled;
		logic [W:0]  sum;
		rn     = 13'(r) * 13'(n);
		scaled = 26'(rn) * 26'd5243;
		sum    = (W+1)'(q) * (W+1)'(n) + (W+1)'(scaled[25:19]);
		return sum[W-1:0];
	endfunction

	assign wr_value    = cfg_data[W-1:0];
	assign recip_prod  = (2*W+1)'(wr_value) * (2*W+1)'(RECIP_100);
	assign wr_quot     = recip_prod[2*W:W+7];
	assign wr_rem_full = wr_value - W'(W'(wr_quot) * W'(7'd100));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= '0;
			integ_gain_q <= '0;
			deriv_gain_q <= '0;
			drive_max_q  <= '1;
			drive_min_q  <= '0;
			dmax_quot_q  <= DMAX_QUOT;
			dmax_rem_q   <= DMAX_REM;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_PROP_GAIN:  prop_gain_q  <= cfg_data[GAIN_W-1:0];
				REG_INTEG_GAIN: integ_gain_q <= cfg_data[GAIN_W-1:0];
				REG_DERIV_GAIN: deriv_gain_q <= cfg_data[GAIN_W-1:0];
				REG_DRIVE_MAX: begin
					drive_max_q <= wr_value;
					dmax_quot_q <= wr_quot;
					dmax_rem_q  <= wr_rem_full[6:0];
				end
				REG_DRIVE_MIN:  drive_min_q  <= wr_value;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		caps_q.coarse_fast <= cap_of(dmax_quot_q, dmax_rem_q, 6'd35);
		caps_q.coarse_slow <= cap_of(dmax_quot_q, dmax_rem_q, 6'd25);
		caps_q.band_normal <= cap_of(dmax_quot_q, dmax_rem_q, 6'd5);
		caps_q.band_stable <= cap_of(dmax_quot_q, dmax_rem_q, 6'd3);
		caps_q.band_tight  <= cap_of(dmax_quot_q, dmax_rem_q, 6'd1);
	end

	assign cfg.prop_gain  = prop_gain_q;
	assign cfg.integ_gain = integ_gain_q;
	assign cfg.deriv_gain = deriv_gain_q;
	assign cfg.drive_max  = drive_max_q;
	assign cfg.drive_min  = drive_min_q;
	assign cfg.caps       = caps_q;

endmodule

`default_nettype wire

// File: hdl/ipsl_error_stage.sv
// input register: error, error differences and error history
// depends on ipsl_pkg
`default_nettype none

module ipsl_error_stage
	import ipsl_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      valid_s1,
	output err_stage_t data_s1,
	input  wire logic stall_down
);

	logic signed [ERR_W-1:0] last_err_q;
	logic signed [ERR_W-1:0] older_err_q;
	logic                    accept;
	logic                    is_run;
	logic                    is_clear;
	logic signed [ERR_W-1:0] err;

	assign in_stall = valid_s1 & stall_down;
	assign accept   = in_valid & ~in_stall;
	assign is_run   = (in_data.mode <= MODE_PI);
	assign is_clear = (in_data.mode == MODE_CLEAR);
	assign err      = $signed({1'b0, in_data.setpoint}) - $signed({1'b0, in_data.measured});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q  <= '0;
			older_err_q <= '0;
			valid_s1    <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= accept & is_run;
			end
			if (accept && is_clear) begin
				last_err_q  <= '0;
				older_err_q <= '0;
			end else if (accept && is_run) begin
				older_err_q <= last_err_q;
				last_err_q  <= err;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_run) begin
			data_s1.mode          <= in_data.mode;
			data_s1.setpoint      <= in_data.setpoint;
			data_s1.measured      <= in_data.measured;
			data_s1.present_drive <= in_data.present_drive;
			data_s1.err           <= err;
			data_s1.d1            <= D1_W'(err) - D1_W'(last_err_q);
			data_s1.d2            <= D2_W'(err) - (D2_W'(last_err_q) <<< 1)
				+ D2_W'(older_err_q);
		end
	end

endmodule

`default_nettype wire

// File: hdl/ipsl_gain_stage.sv
// gain multiplies and band test, registered
// depends on ipsl_pkg
`default_nettype none

module ipsl_gain_stage
	import ipsl_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  cfg_t       cfg,
	input  wire logic  valid_s1,
	input  err_stage_t data_s1,
	output logic       stall_up,
	output logic       valid_s2,
	output gain_stage_t data_s2,
	input  wire logic  stall_down
);

	localparam int NEAR_W = VALUE_WIDTH + 5;

	logic signed [PROD_W-1:0] p_prop;
	logic signed [PROD_W-1:0] p_integ;
	logic signed [PROD_W-1:0] p_deriv;
	logic [NEAR_W-1:0]        ms_x10;
	logic [NEAR_W-1:0]        ms_x20;
	logic [NEAR_W-1:0]        sp_x9;
	logic [NEAR_W-1:0]        sp_x11;
	logic [NEAR_W-1:0]        sp_x19;
	logic [NEAR_W-1:0]        sp_x21;
	logic                     near;

	assign stall_up = valid_s2 & stall_down;

	assign p_prop  = PROD_W'(cfg.prop_gain) * PROD_W'(data_s1.d1);
	assign p_integ = PROD_W'(cfg.integ_gain) * PROD_W'(data_s1.err);
	assign p_deriv = PROD_W'(cfg.deriv_gain) * PROD_W'(data_s1.d2);

	assign ms_x10 = NEAR_W'(data_s1.measured) * NEAR_W'(5'd10);
	assign ms_x20 = NEAR_W'(data_s1.measured) * NEAR_W'(5'd20);
	assign sp_x9  = NEAR_W'(data_s1.setpoint) * NEAR_W'(5'd9);
	assign sp_x11 = NEAR_W'(data_s1.setpoint) * NEAR_W'(5'd11);
	assign sp_x19 = NEAR_W'(data_s1.setpoint) * NEAR_W'(5'd19);
	assign sp_x21 = NEAR_W'(data_s1.setpoint) * NEAR_W'(5'd21);

	// plain pi mode uses the narrower band
	assign near = (data_s1.mode == MODE_PI)
		? ((ms_x20 <= sp_x21) && (ms_x20 >= sp_x19))
		: ((ms_x10 <= sp_x11) && (ms_x10 >= sp_x9));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!stall_up) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_up && valid_s1) begin
			data_s2.mode          <= data_s1.mode;
			data_s2.present_drive <= data_s1.present_drive;
			data_s2.near          <= near;
			data_s2.p_prop        <= p_prop;
			data_s2.p_integ       <= p_integ;
			data_s2.p_deriv       <= p_deriv;
		end
	end

endmodule

`default_nettype wire

// File: hdl/ipsl_limit_stage.sv
// delta sum, cap limiting, truncation, drive clamp and output register
// depends on ipsl_pkg
`default_nettype none

module ipsl_limit_stage
	import ipsl_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  cfg_t        cfg,
	input  wire logic   valid_s2,
	input  gain_stage_t data_s2,
	output logic        stall_up,
	output logic        out_valid,
	output out_item_t   out_data,
	input  wire logic   out_stall
);

	logic                      out_valid_q;
	out_item_t                 out_data_q;
	logic signed [DELTA_W-1:0] delta;
	logic signed [DELTA_W-1:0] delta_c;
	logic signed [DELTA_W-1:0] delta_b;
	logic signed [DELTA_W-1:0] coarse_lim;
	logic signed [DELTA_W-1:0] band_lim;
	logic [VALUE_WIDTH-1:0]    coarse_cap;
	logic [VALUE_WIDTH-1:0]    band_cap;
	logic                      coarse_on;
	logic signed [TOT_W-1:0]   total;
	logic signed [RES_W-1:0]   res;
	logic signed [RES_W-1:0]   res_hi;
	logic signed [RES_W-1:0]   dmax_s;
	logic signed [RES_W-1:0]   dmin_s;
	logic signed [RES_W-1:0]   res_cl;

	assign stall_up = out_valid_q & out_stall;

	always_comb begin
		delta = DELTA_W'(data_s2.p_prop) + DELTA_W'(data_s2.p_integ)
			+ DELTA_W'(data_s2.p_deriv);

		coarse_on  = 1'b0;
		coarse_cap = '0;
		case (data_s2.mode)
			MODE_FAST: begin
				coarse_on  = 1'b1;
				coarse_cap = cfg.caps.coarse_fast;
			end
			MODE_SLOW: begin
				coarse_on  = 1'b1;
				coarse_cap = cfg.caps.coarse_slow;
			end
			default: ;
		endcase

		case (data_s2.mode)
			MODE_NORMAL: band_cap = cfg.caps.band_normal;
			MODE_STABLE: band_cap = cfg.caps.band_stable;
			default:     band_cap = cfg.caps.band_tight;
		endcase

		coarse_lim = $signed(DELTA_W'({coarse_cap, 8'h00}));
		band_lim   = $signed(DELTA_W'({band_cap, 8'h00}));
		delta_c    = (coarse_on && (delta > coarse_lim)) ? coarse_lim : delta;
		delta_b    = (data_s2.near && (delta_c > band_lim)) ? band_lim : delta_c;

		total = $signed(TOT_W'({data_s2.present_drive, 8'h00})) + TOT_W'(delta_b);
		res   = RES_W'(total >>> 8);
		// round toward zero
		if (total[TOT_W-1] && (total[7:0] != 8'h00)) begin
			res = res + RES_W'(1);
		end

		dmax_s = $signed(RES_W'(cfg.drive_max));
		dmin_s = $signed(RES_W'(cfg.drive_min));
		res_hi = (res >= dmax_s) ? dmax_s : res;
		res_cl = (res_hi <= dmin_s) ? dmin_s : res_hi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!stall_up) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_up && valid_s2) begin
			out_data_q.drive       <= res_cl[VALUE_WIDTH-1:0];
			out_data_q.near_target <= data_s2.near;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

// File: hdl/incremental_pid_step_limiter.sv
// top level of the incremental pid step limiter
// depends on ipsl_pkg, ipsl_cfg_regs, ipsl_error_stage, ipsl_gain_stage, ipsl_limit_stage
`default_nettype none

// Incremental PID drive step with positive-delta caps. One input transaction is taken
// per cycle while in_stall is low; a result passes the input register, loaded at the
// accepting edge, then the multiply register and the output register, and
// the pipeline holds under out_stall with in_stall following. Error history is updated
// at acceptance, so back-to-back samples see the previous error at once. Modes 5 (clear
// history), 6 and 7 produce no result.
// The delta caps are registered from drive_max's quotient and remainder, which load
// when it is written; items accepted after the write see the new value.

module incremental_pid_step_limiter
	import ipsl_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output out_item_t             out_data
);

	cfg_t        cfg;
	logic        valid_s1;
	err_stage_t  data_s1;
	logic        stall_s1;
	logic        valid_s2;
	gain_stage_t data_s2;
	logic        stall_s2;

	ipsl_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ipsl_error_stage u_err (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.valid_s1   (valid_s1),
		.data_s1    (data_s1),
		.stall_down (stall_s1)
	);

	ipsl_gain_stage u_gain (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.valid_s1   (valid_s1),
		.data_s1    (data_s1),
		.stall_up   (stall_s1),
		.valid_s2   (valid_s2),
		.data_s2    (data_s2),
		.stall_down (stall_s2)
	);

	ipsl_limit_stage u_limit (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.valid_s2  (valid_s2),
		.data_s2   (data_s2),
		.stall_up  (stall_s2),
		.out_valid (out_valid),
		.out_data  (out_data),
		.out_stall (out_stall)
	);

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// testbench for incremental_pid_step_limiter: random and directed samples, checked by a scoreboard
// holding its own drive predictor; depends on ipsl_pkg and the block's rtl
`timescale 1ns / 100ps

module tb_top;
	import ipsl_pkg::*;

	localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
	localparam logic [VALUE_WIDTH-1:0] VAL_TOP = {VALUE_WIDTH{1'b1}};
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 140;

	class drive_step_scoreboard;
		logic signed [GAIN_W-1:0] prop_gain, integ_gain, deriv_gain;
		logic [VALUE_WIDTH-1:0] drive_max, drive_min;
		longint last_err, older_err;
		out_item_t expected_drives[$];
		int mismatch_count;

		function new();
			prop_gain = '0;
			integ_gain = '0;
			deriv_gain = '0;
			drive_max = VAL_TOP;
			drive_min = '0;
			last_err = 0;
			older_err = 0;
			mismatch_count = 0;
		endfunction

		function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_PROP_GAIN: prop_gain = val[GAIN_W-1:0];
				REG_INTEG_GAIN: integ_gain = val[GAIN_W-1:0];
				REG_DERIV_GAIN: deriv_gain = val[GAIN_W-1:0];
				REG_DRIVE_MAX: drive_max = val[VALUE_WIDTH-1:0];
				REG_DRIVE_MIN: drive_min = val[VALUE_WIDTH-1:0];
				default: ;
			endcase
		endfunction

		function longint step_cap(longint pct);
			return ((longint'(drive_max) * pct) / 100) * 256;
		endfunction

		// works out the next drive for an accepted sample
		function void note_sample(in_item_t it);
			longint sp, ms, pd, err, dlt, res;
			bit near;
			out_item_t exp_item;
			if (it.mode == MODE_CLEAR) begin
				last_err = 0;
				older_err = 0;
				return;
			end
			if (it.mode > MODE_CLEAR)
				return;
			sp = longint'(it.setpoint);
			ms = longint'(it.measured);
			pd = longint'(it.present_drive);
			err = sp - ms;
			dlt = longint'(prop_gain) * (err - last_err) + longint'(integ_gain) * err
				+ longint'(deriv_gain) * (err - 2 * last_err + older_err);
			if (it.mode == MODE_PI)
				near = (20 * ms <= 21 * sp) && (20 * ms >= 19 * sp);
			else
				near = (10 * ms <= 11 * sp) && (10 * ms >= 9 * sp);
			if (it.mode == MODE_FAST && dlt > step_cap(35))
				dlt = step_cap(35);
			if (it.mode == MODE_SLOW && dlt > step_cap(25))
				dlt = step_cap(25);
			if (near) begin
				if (it.mode == MODE_NORMAL && dlt > step_cap(5))
					dlt = step_cap(5);
				else if (it.mode == MODE_STABLE && dlt > step_cap(3))
					dlt = step_cap(3);
				else if (it.mode != MODE_NORMAL && it.mode != MODE_STABLE && dlt > step_cap(1))
					dlt = step_cap(1);
			end
			older_err = last_err;
			last_err = err;
			res = (pd * 256 + dlt) / 256;
			if (res >= longint'(drive_max))
				res = longint'(drive_max);
			if (res <= longint'(drive_min))
				res = longint'(drive_min);
			exp_item.drive = res[VALUE_WIDTH-1:0];
			exp_item.near_target = near;
			expected_drives.push_back(exp_item);
		endfunction

		task report(string msg);
			$display("%0t mismatch: %s", $realtime, msg);
			mismatch_count++;
		endtask

		task check_drive(out_item_t got);
			out_item_t exp_item;
			if (expected_drives.size() == 0) begin
				report($sformatf("unexpected transaction drive=%0d near=%0b",
					got.drive, got.near_target));
				return;
			end
			exp_item = expected_drives.pop_front();
			if (got.drive !== exp_item.drive)
				report($sformatf("drive %0d, expected %0d", got.drive, exp_item.drive));
			if (got.near_target !== exp_item.near_target)
				report($sformatf("near_target %0b, expected %0b",
					got.near_target, exp_item.near_target));
		endtask

		function int pending();
			return expected_drives.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;

	drive_step_scoreboard sb;
	int idle_pct;
	int stall_pct;
	logic [VALUE_WIDTH-1:0] prev_setpoint;

	incremental_pid_step_limiter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(negedge clk) begin
		out_stall <= arst_n && ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && !out_stall)
			sb.check_drive(out_data);
	end

	function automatic in_item_t mk(logic [MODE_W-1:0] mode, int sp, int ms, int pd);
		in_item_t it;
		it.mode = mode;
		it.setpoint = sp[VALUE_WIDTH-1:0];
		it.measured = ms[VALUE_WIDTH-1:0];
		it.present_drive = pd[VALUE_WIDTH-1:0];
		return it;
	endfunction

	function automatic logic [VALUE_WIDTH-1:0] rand_value();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return '0;
		if (r < 10)
			return VAL_TOP;
		return VALUE_WIDTH'($urandom);
	endfunction

	function automatic logic [CFG_W-1:0] rand_gain();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			return '0;
		if (r < 30)
			return CFG_W'($urandom);
		return CFG_W'($urandom_range(2048) - 1024);
	endfunction

	function automatic in_item_t rand_item();
		in_item_t it;
		int r, w, v;
		r = $urandom_range(99);
		if (r < 82)
			it.mode = MODE_W'($urandom_range(MODE_PI, MODE_NORMAL));
		else if (r < 94)
			it.mode = MODE_CLEAR;
		else
			it.mode = $urandom_range(1) ? MODE_SPARE_HI : MODE_SPARE_LO;
		// hold the target for a while so the error history settles
		if ($urandom_range(99) < 60)
			it.setpoint = prev_setpoint;
		else
			it.setpoint = rand_value();
		prev_setpoint = it.setpoint;
		if ($urandom_range(99) < 45) begin
			w = int'(it.setpoint) / 8 + 1;
			v = int'(it.setpoint) + int'($urandom_range(2 * w)) - w;
			if (v < 0)
				v = 0;
			if (v > int'(VAL_TOP))
				v = int'(VAL_TOP);
			it.measured = v[VALUE_WIDTH-1:0];
		end else begin
			it.measured = rand_value();
		end
		it.present_drive = rand_value();
		return it;
	endfunction

	task automatic send_item(in_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_sample(it);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.set_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic write_config(logic [CFG_W-1:0] kp, logic [CFG_W-1:0] ki,
		logic [CFG_W-1:0] kd, logic [CFG_W-1:0] dmax, logic [CFG_W-1:0] dmin);
		write_reg(REG_PROP_GAIN, kp);
		write_reg(REG_INTEG_GAIN, ki);
		write_reg(REG_DERIV_GAIN, kd);
		write_reg(REG_DRIVE_MAX, dmax);
		write_reg(REG_DRIVE_MIN, dmin);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// drain outstanding transactions, then let the pipeline settle
	task automatic wait_idle();
		int n;
		n = 0;
		in_valid <= 1'b0;
		while (sb.pending() != 0 && n < 4000) begin
			@(negedge clk);
			n++;
		end
		if (sb.pending() != 0) begin
			sb.report($sformatf("%0d expected transactions never arrived", sb.pending()));
			sb.expected_drives.delete();
		end
		repeat (8) @(negedge clk);
	endtask

	initial begin
		logic [CFG_W-1:0] dmax, dmin;
		sb = new();
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		prev_setpoint = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset configuration
		send_item(mk(MODE_NORMAL, 5000, 4000, 30000));
		send_item(mk(MODE_FAST, 65535, 0, 65535));
		send_item(mk(MODE_PI, 0, 65535, 0));
		wait_idle();

		write_config(256, 128, 64, 60000, 1000);
		send_item(mk(MODE_CLEAR, 0, 0, 0));
		send_item(mk(MODE_NORMAL, 1000, 1000, 30000));
		send_item(mk(MODE_NORMAL, 1000, 1100, 30000));
		send_item(mk(MODE_NORMAL, 1000, 1101, 30000));
		send_item(mk(MODE_NORMAL, 1000, 900, 30000));
		send_item(mk(MODE_NORMAL, 1000, 899, 30000));
		send_item(mk(MODE_PI, 1000, 1050, 30000));
		send_item(mk(MODE_PI, 1000, 1051, 30000));
		send_item(mk(MODE_PI, 1000, 950, 30000));
		send_item(mk(MODE_PI, 1000, 949, 30000));
		send_item(mk(MODE_FAST, 65535, 0, 0));
		send_item(mk(MODE_SLOW, 65535, 0, 0));
		send_item(mk(MODE_STABLE, 40000, 39000, 20000));
		send_item(mk(MODE_FAST, 40000, 39000, 20000));
		send_item(mk(MODE_NORMAL, 0, 65535, 65535));
		send_item(mk(MODE_SPARE_LO, 65535, 65535, 65535));
		send_item(mk(MODE_SPARE_HI, 0, 0, 0));
		send_item(mk(MODE_NORMAL, 100, 103, 500));
		send_item(mk(MODE_CLEAR, 65535, 65535, 65535));
		send_item(mk(MODE_NORMAL, 0, 0, 0));
		send_item(mk(MODE_PI, 65535, 65535, 65535));
		send_item(mk(MODE_SLOW, 3, 0, 7));
		wait_idle();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 68; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 68; end
				default: begin idle_pct = 9; stall_pct = 9; end
			endcase
			if (ph == 0) begin
				write_config(16'h7fff, 16'h8000, 16'h7fff, VAL_TOP, 0);
			end else if (ph == 1) begin
				write_config(16'h8000, 16'h7fff, 16'h8000, 0, VAL_TOP);
			end else begin
				dmax = ($urandom_range(99) < 20) ? VAL_TOP : rand_value();
				dmin = ($urandom_range(99) < 15) ? rand_value() : CFG_W'($urandom_range(dmax));
				write_config(rand_gain(), rand_gain(), rand_gain(), dmax, dmin);
			end
			repeat (ITEMS_PER_PHASE) send_item(rand_item());
			wait_idle();
		end

		if (sb.mismatch_count == 0)
			$display("incremental_pid_step_limiter test passed");
		else
			$display("incremental_pid_step_limiter test failed");
		$finish;
	end

	initial begin
		#5000000;
		$display("incremental_pid_step_limiter test failed");
		$finish;
	end

endmodule
